// ===== hw/rtl/radix_suffix_number_parser_unit_defines.svh =====
// Assertion macros for the checker file of the number parser.
`ifndef RADIX_SUFFIX_NUMBER_PARSER_UNIT_DEFINES_SVH
`define RADIX_SUFFIX_NUMBER_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RSNP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rsnp: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RSNP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rsnp: next-cycle check failed");

`endif

// ===== hw/rtl/rsnp_pkg.sv =====
package rsnp_pkg;

	// Width of the running accumulators; a value above it is an overflow.
	localparam int VALUE_BITS = 32;

	// Depth of the request queue between front and back.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Radix codes on the result.
	localparam logic [1:0] RADIX_BIN = 2'd0;
	localparam logic [1:0] RADIX_OCT = 2'd1;
	localparam logic [1:0] RADIX_DEC = 2'd2;
	localparam logic [1:0] RADIX_HEX = 2'd3;

	// Digit value of a character that is no digit at all.
	localparam logic [5:0] DIGIT_BAD = 6'h3F;
	localparam logic [5:0] DEC_BASE  = 6'd10;

	// Character codes.
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_A_UP   = 8'h41;
	localparam logic [7:0] CH_F_UP   = 8'h46;
	localparam logic [7:0] CH_Z_UP   = 8'h5A;
	localparam logic [7:0] CH_A_LO   = 8'h61;
	localparam logic [7:0] CH_F_LO   = 8'h66;
	localparam logic [7:0] CH_Z_LO   = 8'h7A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_B      = 8'h42;
	localparam logic [7:0] CH_D      = 8'h44;
	localparam logic [7:0] CH_H      = 8'h48;
	localparam logic [7:0] CH_O      = 8'h4F;
	localparam logic [7:0] CH_Q      = 8'h51;
	localparam logic [7:0] CASE_GAP  = 8'd32;
	localparam logic [7:0] LETTER_OFS = 8'd10;

	// Work the back end does for one queued request.
	typedef enum logic [1:0] {
		OP_START,
		OP_START_KEEP,
		OP_KEEP,
		OP_FINISH
	} op_t;

	// Suffix found on the terminating character.
	typedef enum logic [1:0] {
		SFX_NONE,
		SFX_OCT,
		SFX_HEX
	} sfx_t;

	typedef struct packed {
		op_t        op;
		sfx_t       sfx;
		logic [7:0] up;
		logic [5:0] digit;
	} q_entry_t;

	function automatic logic [7:0] fold_upper(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c inside {[CH_A_LO:CH_Z_LO]})
			r = c - CASE_GAP;
		return r;
	endfunction

	function automatic logic [5:0] decode_digit(input logic [7:0] c);
		logic [5:0] r;
		r = DIGIT_BAD;
		if (c inside {[CH_0:CH_9]})
			r = 6'(c - CH_0);
		else if (c inside {[CH_A_UP:CH_Z_UP]})
			r = 6'(c - CH_A_UP + LETTER_OFS);
		return r;
	endfunction

	function automatic logic is_hex_char(input logic [7:0] c);
		return (c inside {[CH_0:CH_9]}) || (c inside {[CH_A_UP:CH_F_UP]}) ||
			(c inside {[CH_A_LO:CH_F_LO]});
	endfunction

endpackage

// ===== hw/rtl/rsnp_front.sv =====
module rsnp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         ch,
	input  logic               first,
	output logic               push,
	output rsnp_pkg::q_entry_t push_data,
	input  logic               full
);
	import rsnp_pkg::*;

	logic       active_q;
	logic       accept;
	logic       want;
	logic       cont;
	logic       dollar;
	logic [7:0] up;

	assign in_ready = !full;
	assign accept   = in_valid && !full;
	assign up       = fold_upper(ch);
	assign dollar   = (ch == CH_DOLLAR);
	assign cont     = is_hex_char(ch) || dollar;

	// Classify the character into a back-end request
	always_comb begin
		want            = 1'b0;
		push_data.op    = OP_KEEP;
		push_data.up    = up;
		push_data.digit = decode_digit(up);
		case (up)
			CH_O, CH_Q: push_data.sfx = SFX_OCT;
			CH_H:       push_data.sfx = SFX_HEX;
			default:    push_data.sfx = SFX_NONE;
		endcase
		if (first) begin
			want         = 1'b1;
			push_data.op = dollar ? OP_START : OP_START_KEEP;
		end else if (active_q) begin
			if (cont) begin
				want         = !dollar;
				push_data.op = OP_KEEP;
			end else begin
				want         = 1'b1;
				push_data.op = OP_FINISH;
			end
		end
	end

	assign push = accept && want;

	// Track whether a literal is open; drop stray characters otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (accept) begin
			if (first)
				active_q <= 1'b1;
			else if (!cont)
				active_q <= 1'b0;
		end
	end

endmodule

// ===== hw/rtl/rsnp_queue.sv =====
module rsnp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rsnp_pkg::q_entry_t push_data,
	output logic               full,
	output logic               q_valid,
	output rsnp_pkg::q_entry_t q_data,
	input  logic               pop
);
	import rsnp_pkg::*;

	q_entry_t             mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_q;
	logic [Q_PTR_W-1:0]   rd_q;
	logic [Q_CNT_W-1:0]   cnt_q;

	assign full    = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_data  = mem_q[rd_q];

	// Store requests
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== hw/rtl/rsnp_back.sv =====
module rsnp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  rsnp_pkg::q_entry_t q_data,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        value,
	output logic               error,
	output logic               suffix_taken,
	output logic [1:0]         radix_used
);
	import rsnp_pkg::*;

	localparam int VB = VALUE_BITS;

	logic [VB-1:0] bin_q, oct_q, dec_q, hex_q, binb_q, decb_q;
	logic [5:0]    bad_q;
	logic [7:0]    last_q;
	logic          nz_q;

	logic [VB-1:0] base_bin, base_oct, base_dec, base_hex, base_binb, base_decb;
	logic [5:0]    base_bad;
	logic [7:0]    base_last;
	logic          base_nz;

	logic [VB-1:0] nxt_bin, nxt_oct, nxt_dec, nxt_hex, nxt_binb, nxt_decb;
	logic [5:0]    nxt_bad;
	logic [7:0]    nxt_last;
	logic          nxt_nz;

	logic [VB+3:0] dec_wide;
	logic [VB+3:0] dec_prod;
	logic [5:0]    d;
	logic          clr;
	logic          keep;
	logic          fin;

	logic [VB-1:0] sel_val;
	logic          sel_bad;
	logic          sel_sfx;
	logic [1:0]    sel_radix;
	logic [63:0]   sel_wide;

	logic          out_valid_q;
	logic [31:0]   value_q;
	logic          error_q;
	logic          suffix_q;
	logic [1:0]    radix_q;

	assign d    = q_data.digit;
	assign clr  = (q_data.op == OP_START) || (q_data.op == OP_START_KEEP);
	assign keep = (q_data.op == OP_START_KEEP) || (q_data.op == OP_KEEP);
	assign fin  = (q_data.op == OP_FINISH);
	assign pop  = q_valid && (!fin || !out_valid_q || out_ready);

	// Start from a cleared literal or from the running state
	always_comb begin
		base_bin  = clr ? '0 : bin_q;
		base_oct  = clr ? '0 : oct_q;
		base_dec  = clr ? '0 : dec_q;
		base_hex  = clr ? '0 : hex_q;
		base_binb = clr ? '0 : binb_q;
		base_decb = clr ? '0 : decb_q;
		base_bad  = clr ? '0 : bad_q;
		base_last = clr ? '0 : last_q;
		base_nz   = clr ? 1'b0 : nz_q;
	end

	// Times ten as two shifts and one add, with four guard bits for overflow
	assign dec_wide = (VB+4)'(base_dec);
	assign dec_prod = (dec_wide << 3) + (dec_wide << 1) + (VB+4)'(d);

	// Fold one digit into all four accumulators
	always_comb begin
		nxt_bin  = base_bin;
		nxt_oct  = base_oct;
		nxt_dec  = base_dec;
		nxt_hex  = base_hex;
		nxt_binb = base_binb;
		nxt_decb = base_decb;
		nxt_bad  = base_bad;
		nxt_last = base_last;
		nxt_nz   = base_nz;
		if (keep) begin
			nxt_binb   = base_bin;
			nxt_decb   = base_dec;
			nxt_bad[4] = base_bad[0];
			nxt_bad[5] = base_bad[2];
			nxt_last   = q_data.up;
			nxt_nz     = 1'b1;
			if (!base_bad[0]) begin
				if (d[5:1] != '0 || base_bin[VB-1])
					nxt_bad[0] = 1'b1;
				else
					nxt_bin = {base_bin[VB-2:0], d[0]};
			end
			if (!base_bad[1]) begin
				if (d[5:3] != '0 || base_oct[VB-1 -: 3] != '0)
					nxt_bad[1] = 1'b1;
				else
					nxt_oct = {base_oct[VB-4:0], d[2:0]};
			end
			if (!base_bad[2]) begin
				if (d >= DEC_BASE || dec_prod[VB+3 -: 4] != '0)
					nxt_bad[2] = 1'b1;
				else
					nxt_dec = dec_prod[VB-1:0];
			end
			if (!base_bad[3]) begin
				if (d[5:4] != '0 || base_hex[VB-1 -: 4] != '0)
					nxt_bad[3] = 1'b1;
				else
					nxt_hex = {base_hex[VB-5:0], d[3:0]};
			end
		end
	end

	// Pick the radix for a finished literal
	always_comb begin
		sel_sfx = 1'b0;
		if (q_data.sfx == SFX_OCT) begin
			sel_sfx   = 1'b1;
			sel_radix = RADIX_OCT;
			sel_val   = oct_q;
			sel_bad   = bad_q[1];
		end else if (q_data.sfx == SFX_HEX) begin
			sel_sfx   = 1'b1;
			sel_radix = RADIX_HEX;
			sel_val   = hex_q;
			sel_bad   = bad_q[3];
		end else if (nz_q && last_q == CH_B) begin
			sel_radix = RADIX_BIN;
			sel_val   = binb_q;
			sel_bad   = bad_q[4];
		end else if (nz_q && last_q == CH_D) begin
			sel_radix = RADIX_DEC;
			sel_val   = decb_q;
			sel_bad   = bad_q[5];
		end else begin
			sel_radix = RADIX_DEC;
			sel_val   = dec_q;
			sel_bad   = bad_q[2];
		end
	end

	assign sel_wide = 64'(sel_val);

	// Update literal state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q  <= '0;
			oct_q  <= '0;
			dec_q  <= '0;
			hex_q  <= '0;
			binb_q <= '0;
			decb_q <= '0;
			bad_q  <= '0;
			last_q <= '0;
			nz_q   <= 1'b0;
		end else if (pop && !fin) begin
			bin_q  <= nxt_bin;
			oct_q  <= nxt_oct;
			dec_q  <= nxt_dec;
			hex_q  <= nxt_hex;
			binb_q <= nxt_binb;
			decb_q <= nxt_decb;
			bad_q  <= nxt_bad;
			last_q <= nxt_last;
			nz_q   <= nxt_nz;
		end
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && fin) begin
			value_q  <= sel_bad ? '0 : sel_wide[31:0];
			error_q  <= sel_bad;
			suffix_q <= sel_sfx;
			radix_q  <= sel_radix;
		end
	end

	assign out_valid    = out_valid_q;
	assign value        = value_q;
	assign error        = error_q;
	assign suffix_taken = suffix_q;
	assign radix_used   = radix_q;

endmodule

// ===== hw/rtl/radix_suffix_number_parser_unit.sv =====
// Number literal parser with radix suffixes.
// Input channel (in_valid/in_ready, ch, first): one character per request.
// first marks the opening character of a literal; a new first drops any
// unfinished literal. Hex digits and '$' continue a literal ('$' is skipped);
// any other character ends it and yields one result request on the output
// channel (out_valid/out_ready, value, error, suffix_taken, radix_used).
// Characters with first low outside a literal are taken and dropped.
// Throughput: one character per cycle while the queue is not full; in_ready
// follows only the fill level of the two-entry request queue, so a stalled
// receiver stops the input once the output register and the queue are full.
// A terminating character goes into the request queue; the back end pops it
// once the output register is free and registers the result there.
// Reset clears the open-literal flag, the queue and the output valid flag;
// no result is pending after reset.
module radix_suffix_number_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        first,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] value,
	output logic        error,
	output logic        suffix_taken,
	output logic [1:0]  radix_used
);
	import rsnp_pkg::*;

	logic     push;
	logic     full;
	logic     q_valid;
	logic     pop;
	q_entry_t push_data;
	q_entry_t q_data;

	rsnp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.ch        (ch),
		.first     (first),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	rsnp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.pop       (pop)
	);

	rsnp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.value        (value),
		.error        (error),
		.suffix_taken (suffix_taken),
		.radix_used   (radix_used)
	);

endmodule

// ===== hw/rtl/rsnp_checker.sv =====
`include "radix_suffix_number_parser_unit_defines.svh"

module rsnp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] value,
	input logic        error,
	input logic        suffix_taken,
	input logic [1:0]  radix_used
);
	import rsnp_pkg::*;

	// A waiting input request stays offered
	`RSNP_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid)

	// A stalled result stays offered
	`RSNP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

	// An error always reports value zero
	`RSNP_ASSERT_NOW(a_err_zero, out_valid && error, value == '0)

	// A consumed suffix only selects octal or hex
	`RSNP_ASSERT_NOW(a_sfx_radix, out_valid && suffix_taken,
		radix_used == RADIX_OCT || radix_used == RADIX_HEX)

	// Without a suffix only binary or decimal is chosen
	`RSNP_ASSERT_NOW(a_nosfx_radix, out_valid && !suffix_taken,
		radix_used == RADIX_BIN || radix_used == RADIX_DEC)

endmodule

bind radix_suffix_number_parser_unit rsnp_checker u_rsnp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.value        (value),
	.error        (error),
	.suffix_taken (suffix_taken),
	.radix_used   (radix_used)
);
